/* rtl/string_to_integer_parser_assert.svh */
// Assertion macros used by the parser top level.
`ifndef STRING_TO_INTEGER_PARSER_ASSERT_SVH
`define STRING_TO_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, masked while rst is high.
`define STOI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parser assertion failed");

// Next-cycle implication, sampled on clk, masked while rst is high.
`define STOI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parser assertion failed");

`endif

/* rtl/stoi_pkg.sv */
// Package with types and constants for the string to integer parser.
package stoi_pkg;

  localparam int COUNT_BITS = 16;
  localparam int BASE_BITS  = 6;
  localparam int VALUE_BITS = 64;
  localparam int CONS_BITS  = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_PREFIX,
    PH_PENDZ,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic [VALUE_BITS-1:0]   acc;
    logic                    neg;
    logic [BASE_BITS-1:0]    base;
    logic [COUNT_BITS-1:0]   cnt;
  } parse_state_t;

  typedef struct packed {
    logic                    emit;
    logic [VALUE_BITS-1:0]   value;
    logic [CONS_BITS-1:0]    consumed;
  } parse_result_t;

endpackage

/* rtl/stoi_next.sv */
// Next-state and result logic for one character of the parser.
module stoi_next (
  input  stoi_pkg::parse_state_t  cur,
  input  logic [7:0]              ch,
  input  logic                    start_req,
  input  logic [5:0]              radix,
  output stoi_pkg::parse_state_t  nxt,
  output stoi_pkg::parse_result_t res
);
  import stoi_pkg::*;

  logic                  alnum;
  logic [BASE_BITS-1:0]  dig;

  always_comb begin
    alnum = 1'b1;
    dig   = '0;
    if (ch inside {[CH_ZERO:CH_NINE]}) begin
      dig = BASE_BITS'(ch - CH_ZERO);
    end else if (ch inside {[CH_LA:CH_LZ]}) begin
      dig = BASE_BITS'(ch - CH_LA + 8'd10);
    end else if (ch inside {[CH_UA:CH_UZ]}) begin
      dig = BASE_BITS'(ch - CH_UA + 8'd10);
    end else begin
      alnum = 1'b0;
    end
  end

  always_comb begin
    parse_state_t                     st;
    logic                             do_prefix;
    logic                             do_pendz;
    logic                             do_digit;
    logic                             bump;
    logic [VALUE_BITS+BASE_BITS-1:0]  prod;

    st        = cur;
    do_prefix = 1'b0;
    do_pendz  = 1'b0;
    do_digit  = 1'b0;
    bump      = 1'b0;
    res.emit  = 1'b0;

    if (start_req) begin
      st.phase = PH_LEAD;
      st.acc   = '0;
      st.neg   = 1'b0;
      st.base  = radix;
      st.cnt   = '0;
    end

    case (st.phase)
      PH_IDLE: begin
      end
      PH_LEAD: begin
        if (ch == CH_SPACE || ch == CH_TAB) begin
          bump = 1'b1;
        end else if (ch == CH_PLUS) begin
          st.phase = PH_PREFIX;
          bump     = 1'b1;
        end else if (ch == CH_MINUS) begin
          st.phase = PH_PREFIX;
          st.neg   = 1'b1;
          bump     = 1'b1;
        end else begin
          do_prefix = 1'b1;
        end
      end
      PH_PREFIX: do_prefix = 1'b1;
      PH_PENDZ:  do_pendz  = 1'b1;
      PH_DIGITS: do_digit  = 1'b1;
      default:   st.phase  = PH_IDLE;
    endcase

    if (do_prefix) begin
      if ((st.base == BASE_AUTO || st.base == BASE_HEX) && ch == CH_ZERO) begin
        // The zero may open a hex prefix, so the decision waits a character.
        st.phase = PH_PENDZ;
        bump     = 1'b1;
      end else begin
        if (st.base == BASE_AUTO) begin
          st.base = BASE_DEC;
        end
        do_digit = 1'b1;
      end
    end

    if (do_pendz) begin
      if (ch == CH_X) begin
        st.base  = BASE_HEX;
        st.phase = PH_DIGITS;
        bump     = 1'b1;
      end else begin
        if (st.base == BASE_AUTO) begin
          st.base = BASE_OCT;
        end
        do_digit = 1'b1;
      end
    end

    prod = {{BASE_BITS{1'b0}}, st.acc} * {{VALUE_BITS{1'b0}}, st.base};

    res.value    = st.neg ? (~st.acc + 1'b1) : st.acc;
    res.consumed = CONS_BITS'(st.cnt);

    if (do_digit) begin
      if (alnum && dig < st.base) begin
        st.phase = PH_DIGITS;
        st.acc   = prod[VALUE_BITS-1:0] + {{(VALUE_BITS-BASE_BITS){1'b0}}, dig};
        bump     = 1'b1;
      end else begin
        res.emit = 1'b1;
        st.phase = PH_IDLE;
      end
    end

    if (bump && st.cnt != COUNT_MAX) begin
      st.cnt = st.cnt + 1'b1;
    end

    nxt = st;
  end

endmodule

/* rtl/string_to_integer_parser.sv */
// Top level of the streaming string to integer parser.
//
//  group    role    payload (low bit first)
//  s_axis   in      tdata[7:0] ch, tuser start_req
//  m_axis   out     tdata[63:0] value, tdata[79:64] consumed
//  cfg      write   cfg_data[5:0] radix
//
// A result appears in the cycle after the character that ends the string.
// The 64 by 6 multiply-accumulate on the accumulator sets the clock period.
// Reset clears the parser to idle and the radix to automatic. One character
// is taken each cycle but while a result waits unaccepted the input is held;
// when the result is taken in the same cycle the next character flows on.
module string_to_integer_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] ch
  input  logic         s_axis_tuser,   // [0] start_req
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,   // [63:0] value, [79:64] consumed
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data
);
  import stoi_pkg::*;

  parse_state_t         state;
  parse_state_t         state_next;
  parse_result_t        res;
  logic [BASE_BITS-1:0] radix;
  logic                 accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  stoi_next u_next (
    .cur       (state),
    .ch        (s_axis_tdata),
    .start_req (s_axis_tuser),
    .radix     (radix),
    .nxt       (state_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= BASE_AUTO;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_IDLE;
      state.acc   <= '0;
      state.neg   <= 1'b0;
      state.base  <= '0;
      state.cnt   <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept && res.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.emit) begin
      m_axis_tdata <= {res.consumed, res.value};
    end
  end

`include "string_to_integer_parser_assert.svh"

  // A result only ever follows an accepted character transaction.
  `STOI_ASSERT_NOW(a_result_from_input, $rose(m_axis_tvalid), $past(accept))
  // The terminating character always returns the parser to idle.
  `STOI_ASSERT_NEXT(a_idle_after_emit, accept && res.emit, state.phase == PH_IDLE)
  // A start that does not end at once leaves a string in progress.
  `STOI_ASSERT_NEXT(a_start_active, accept && s_axis_tuser && !res.emit,
                    state.phase != PH_IDLE)

endmodule
